@@ src/bmprc_pkg.sv @@
`timescale 1ns / 1ps

package bmprc_pkg;

  // Register map, word index within the APB window
  typedef enum logic [2:0] {
    REG_SOURCE_WIDTH  = 3'd0,
    REG_SOURCE_HEIGHT = 3'd1,
    REG_WINDOW_LEFT   = 3'd2,
    REG_WINDOW_TOP    = 3'd3,
    REG_WINDOW_WIDTH  = 3'd4,
    REG_WINDOW_HEIGHT = 3'd5
  } bmprc_reg_t;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);

  // Crop geometry as held in the register file
  typedef struct packed {
    logic [12:0] source_width;
    logic [12:0] source_height;
    logic [11:0] window_left;
    logic [11:0] window_top;
    logic [12:0] window_width;
    logic [12:0] window_height;
  } bmprc_cfg_t;

  // One classified byte handed from front to back
  typedef struct packed {
    logic [7:0] data;
    logic [1:0] pad;    // zero bytes to append after data
    logic       err;    // invalid window marker
    logic       done;   // last row end of the window
  } bmprc_entry_t;

endpackage

@@ src/bmp_row_padded_crop_stream.sv @@
`timescale 1ns / 1ps
// Channel  | Handshake            | Payload
// ---------+----------------------+---------------------------------------------
// input    | in_valid / in_stall  | in_pixel_byte, in_frame_start
// result   | out_valid / out_stall| out_out_byte, out_run_last, out_image_done,
//          |                      | out_window_error
// config   | APB psel/penable     | paddr, pwdata, prdata (32 bit)
//
// One input byte per clock while in_stall is low; a kept byte at a row end yields
// 1 to 4 result bytes (data plus padding), which the output expander emits.
// A four-entry queue between classifier and expander absorbs padding bursts;
// in_stall rises only when that queue is full.
// With the queue empty, a byte's first result passes through the queue and then
// the output register before it is offered on the result side.
// Synchronous active-low reset clears counters, queue and registers to defaults.

module bmp_row_padded_crop_stream #(
  parameter int unsigned MAX_DIMENSION = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_pixel_byte,
  input  logic        in_frame_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_out_byte,
  output logic        out_run_last,
  output logic        out_image_done,
  output logic        out_window_error
);

  bmprc_pkg::bmprc_cfg_t   cfg_r;
  bmprc_pkg::bmprc_reg_t   reg_idx;
  bmprc_pkg::bmprc_entry_t push_data, pop_data;
  logic                    wr_en;
  logic                    push, pop, fifo_full, fifo_empty;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = bmprc_pkg::bmprc_reg_t'(paddr[4:2]);

  // Register file write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.source_width  <= 13'd1;
      cfg_r.source_height <= 13'd1;
      cfg_r.window_left   <= '0;
      cfg_r.window_top    <= '0;
      cfg_r.window_width  <= 13'd1;
      cfg_r.window_height <= 13'd1;
    end else if (wr_en) begin
      unique case (reg_idx)
        bmprc_pkg::REG_SOURCE_WIDTH:  cfg_r.source_width  <= pwdata[12:0];
        bmprc_pkg::REG_SOURCE_HEIGHT: cfg_r.source_height <= pwdata[12:0];
        bmprc_pkg::REG_WINDOW_LEFT:   cfg_r.window_left   <= pwdata[11:0];
        bmprc_pkg::REG_WINDOW_TOP:    cfg_r.window_top    <= pwdata[11:0];
        bmprc_pkg::REG_WINDOW_WIDTH:  cfg_r.window_width  <= pwdata[12:0];
        bmprc_pkg::REG_WINDOW_HEIGHT: cfg_r.window_height <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  // Register file read
  always_comb begin
    unique case (reg_idx)
      bmprc_pkg::REG_SOURCE_WIDTH:  prdata = 32'(cfg_r.source_width);
      bmprc_pkg::REG_SOURCE_HEIGHT: prdata = 32'(cfg_r.source_height);
      bmprc_pkg::REG_WINDOW_LEFT:   prdata = 32'(cfg_r.window_left);
      bmprc_pkg::REG_WINDOW_TOP:    prdata = 32'(cfg_r.window_top);
      bmprc_pkg::REG_WINDOW_WIDTH:  prdata = 32'(cfg_r.window_width);
      bmprc_pkg::REG_WINDOW_HEIGHT: prdata = 32'(cfg_r.window_height);
      default:                      prdata = '0;
    endcase
  end

  bmprc_front #(
    .MAX_DIMENSION(MAX_DIMENSION)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_pixel_byte (in_pixel_byte),
    .in_frame_start(in_frame_start),
    .fifo_full     (fifo_full),
    .push          (push),
    .push_data     (push_data)
  );

  bmprc_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(push_data),
    .full     (fifo_full),
    .pop      (pop),
    .empty    (fifo_empty),
    .pop_data (pop_data)
  );

  bmprc_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .fifo_empty      (fifo_empty),
    .fifo_data       (pop_data),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_out_byte    (out_out_byte),
    .out_run_last    (out_run_last),
    .out_image_done  (out_image_done),
    .out_window_error(out_window_error)
  );

endmodule

@@ src/bmprc_front.sv @@
`timescale 1ns / 1ps

module bmprc_front #(
  parameter int unsigned MAX_DIMENSION = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bmprc_pkg::bmprc_cfg_t cfg,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_pixel_byte,
  input  logic                  in_frame_start,
  input  logic                  fifo_full,
  output logic                  push,
  output bmprc_pkg::bmprc_entry_t push_data
);

  logic [14:0] byte_column_r, byte_column_nxt;
  logic [12:0] file_row_r, file_row_nxt;

  logic        accept;
  logic        win_ok;
  logic [13:0] h_sum, v_sum;
  logic [12:0] first_row, last_row;
  logic [13:0] first_col;
  logic [14:0] width3;
  logic [15:0] last_col;
  logic [15:0] stride;
  logic [14:0] col_eff;
  logic [12:0] row_eff;
  logic [15:0] col_inc;
  logic [13:0] row_inc;
  logic        in_win;
  logic        row_end;

  assign in_stall = fifo_full;
  assign accept   = in_valid & ~fifo_full;

  // Window geometry and bounds check
  always_comb begin
    h_sum  = 14'(cfg.window_left) + 14'(cfg.window_width);
    v_sum  = 14'(cfg.window_top) + 14'(cfg.window_height);
    win_ok = (cfg.source_width != '0) && (cfg.source_height != '0) &&
             (cfg.window_width != '0) && (cfg.window_height != '0) &&
             (32'(cfg.source_width) <= 32'(MAX_DIMENSION)) &&
             (32'(cfg.source_height) <= 32'(MAX_DIMENSION)) &&
             (h_sum <= 14'(cfg.source_width)) &&
             (v_sum <= 14'(cfg.source_height));
    first_row = cfg.source_height - 13'(cfg.window_top) - cfg.window_height;
    last_row  = cfg.source_height - 13'(cfg.window_top) - 13'd1;
    first_col = {1'b0, cfg.window_left, 1'b0} + 14'(cfg.window_left);
    width3    = {1'b0, cfg.window_width, 1'b0} + 15'(cfg.window_width);
    last_col  = 16'(first_col) + 16'(width3) - 16'd1;
    stride    = (({2'b0, cfg.source_width, 1'b0} + 16'(cfg.source_width)) + 16'd3)
                & ~16'd3;
  end

  // Classify the byte against the window
  always_comb begin
    col_eff = in_frame_start ? '0 : byte_column_r;
    row_eff = in_frame_start ? '0 : file_row_r;
    in_win  = (row_eff >= first_row) && (row_eff <= last_row) &&
              (16'(col_eff) >= 16'(first_col)) && (16'(col_eff) <= last_col);
    row_end = (16'(col_eff) == last_col);

    push           = accept & (~win_ok | in_win);
    push_data.data = win_ok ? in_pixel_byte : 8'd0;
    push_data.err  = ~win_ok;
    push_data.pad  = (win_ok & row_end) ? cfg.window_width[1:0] : 2'd0;
    push_data.done = win_ok & row_end & (row_eff == last_row);
  end

  // Advance column and row; hold on an invalid window
  always_comb begin
    col_inc         = 16'(col_eff) + 16'd1;
    row_inc         = 14'(row_eff) + 14'd1;
    byte_column_nxt = col_eff;
    file_row_nxt    = row_eff;
    if (win_ok) begin
      if (col_inc >= stride) begin
        byte_column_nxt = '0;
        file_row_nxt    = (row_inc >= 14'(cfg.source_height)) ? '0 : row_inc[12:0];
      end else begin
        byte_column_nxt = col_inc[14:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_column_r <= '0;
      file_row_r    <= '0;
    end else if (accept) begin
      byte_column_r <= byte_column_nxt;
      file_row_r    <= file_row_nxt;
    end
  end

endmodule

@@ src/bmprc_fifo.sv @@
`timescale 1ns / 1ps

module bmprc_fifo (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  bmprc_pkg::bmprc_entry_t push_data,
  output logic                    full,
  input  logic                    pop,
  output logic                    empty,
  output bmprc_pkg::bmprc_entry_t pop_data
);

  bmprc_pkg::bmprc_entry_t entries_r [bmprc_pkg::FIFO_DEPTH];

  logic [bmprc_pkg::FIFO_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [bmprc_pkg::FIFO_PTR_W:0]   count_r, count_nxt;

  assign full     = (count_r == (bmprc_pkg::FIFO_PTR_W + 1)'(bmprc_pkg::FIFO_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = entries_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + 1'b1;
    if (pop && !push) count_nxt = count_r - 1'b1;
  end

  // Store entry on push
  always_ff @(posedge clk) begin
    if (push) entries_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

endmodule

@@ src/bmprc_back.sv @@
`timescale 1ns / 1ps

module bmprc_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    fifo_empty,
  input  bmprc_pkg::bmprc_entry_t fifo_data,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [7:0]              out_out_byte,
  output logic                    out_run_last,
  output logic                    out_image_done,
  output logic                    out_window_error
);

  bmprc_pkg::bmprc_entry_t cur_r, cur_nxt;
  logic                    cur_valid_r, cur_valid_nxt;
  logic [1:0]              sub_r, sub_nxt;
  logic                    last;
  logic                    take;

  assign last = (sub_r == cur_r.pad);

  // Emit data byte then padding; load next entry after the last transfer
  always_comb begin
    take          = ~cur_valid_r | (~out_stall & last);
    pop           = take & ~fifo_empty;
    cur_valid_nxt = cur_valid_r;
    cur_nxt       = cur_r;
    sub_nxt       = sub_r;
    if (take) begin
      cur_valid_nxt = ~fifo_empty;
      cur_nxt       = fifo_data;
      sub_nxt       = '0;
    end else if (!out_stall) begin
      sub_nxt = sub_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      sub_r       <= '0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      sub_r       <= sub_nxt;
    end
  end

  assign out_valid        = cur_valid_r;
  assign out_out_byte     = (sub_r == 2'd0) ? cur_r.data : 8'd0;
  assign out_run_last     = last;
  assign out_image_done   = last & cur_r.done;
  assign out_window_error = cur_r.err;

endmodule
